FILE: src/first_fit_segment_allocator_defines.svh
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FFSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FFSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/ffsa_pkg.sv
// Package with types and status codes of the segment allocator.
package ffsa_pkg;
  localparam int OffsetW = 15;
  localparam int SizeW   = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_UP,
    S_DN,
    S_DONE
  } state_t;
endpackage

FILE: src/ffsa_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ffsa_req_if;
  import ffsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [SizeW-1:0]     request_size;
  logic [OffsetW-1:0]   block_offset;
  modport source (output valid, command, request_size, block_offset, input ready);
  modport sink   (input valid, command, request_size, block_offset, output ready);
endinterface

interface ffsa_rsp_if;
  import ffsa_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [OffsetW-1:0] granted_offset;
  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

FILE: src/first_fit_segment_allocator.sv
// First-fit segment allocator with coalescing, table held in one memory.
//
//  channel | role   | payload
//  req     | sink   | command, request_size, block_offset
//  rsp     | source | status, granted_offset
//
// The scan streams the table at one entry per cycle, and a split or a merge
// shifts the later entries at one per cycle before the response is valid.
// After reset the S_INIT state writes entry 0 as a free segment at offset zero;
// entries beyond the count are never used. The response register holds its
// item while rsp.ready is low; no new request is taken until it has gone.
module first_fit_segment_allocator #(
  parameter int POOL_BYTES   = 32768,
  parameter int MAX_SEGMENTS = 64
) (
  input logic clk,
  input logic rst,
  ffsa_req_if.sink   req,
  ffsa_rsp_if.source rsp
);
  import ffsa_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int PW = $clog2(POOL_BYTES + 1);
  localparam int LW = (PW + 1 > SizeW) ? PW + 1 : SizeW;
  localparam int MW = (PW > OffsetW) ? PW : OffsetW;

  // Entry holds start offset and used mark.
  logic [PW:0] mem [MAX_SEGMENTS];
  logic [PW:0] rd_data;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [PW:0] wr_data;
  logic we;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] j, j_next;       // entry whose word is in rd_data while scanning
  logic [CW-1:0] k, k_next;       // shift cursor
  logic [CW-1:0] lim, lim_next;   // last entry written by an upward shift
  logic gap2, gap2_next;          // downward shift closes two entries
  logic cmd, cmd_next;
  logic [SizeW-1:0] size, size_next;
  logic [OffsetW-1:0] offs, offs_next;
  logic [PW-1:0] p_start, p_start_next;
  logic p_used, p_used_next;
  logic pp_used, pp_used_next;
  logic [PW:0] hold, hold_next;   // word carried during an upward shift
  logic rsp_v, rsp_v_next;
  logic [1:0] st, st_next;
  logic [OffsetW-1:0] gr, gr_next;

  logic have;
  logic [PW-1:0] cur_start;
  logic cur_used;
  logic [PW-1:0] seg_end;
  logic [LW-1:0] len;
  logic prev_free, next_free;
  logic [CW-1:0] dst, new_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= CW'(1);
      rsp_v <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rsp_v <= rsp_v_next;
    end
    j <= j_next; k <= k_next; lim <= lim_next; gap2 <= gap2_next; cmd <= cmd_next;
    size <= size_next; offs <= offs_next; p_start <= p_start_next;
    p_used <= p_used_next; pp_used <= pp_used_next; hold <= hold_next;
    st <= st_next; gr <= gr_next;
  end

  assign req.ready = (state == S_IDLE) && !rsp_v;
  assign rsp.valid = rsp_v;
  assign rsp.status = st;
  assign rsp.granted_offset = gr;

  always_comb begin
    state_next = state; count_next = count; j_next = j; k_next = k;
    lim_next = lim; gap2_next = gap2; cmd_next = cmd; size_next = size;
    offs_next = offs; p_start_next = p_start; p_used_next = p_used;
    pp_used_next = pp_used; hold_next = hold; rsp_v_next = rsp_v;
    st_next = st; gr_next = gr;
    rd_addr = '0; we = 1'b0; wr_addr = '0; wr_data = '0;
    // While scanning, rd_data holds entry j and p_* hold entry j-1, which is
    // the one judged; its end is the start of entry j or the pool end.
    have = (j < count);
    cur_start = rd_data[PW:1];
    cur_used = rd_data[0];
    seg_end = have ? cur_start : PW'(POOL_BYTES);
    len = LW'(seg_end) - LW'(p_start);
    prev_free = !pp_used;
    next_free = have && !cur_used;
    dst = '0; new_count = count;
    if (rsp_v && rsp.ready) rsp_v_next = 1'b0;
    unique case (state)
      S_INIT: begin
        we = 1'b1; wr_addr = '0; wr_data = '0;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && req.ready) begin
          cmd_next = req.command; size_next = req.request_size;
          offs_next = req.block_offset; j_next = '0; rd_addr = '0;
          if (req.command == CMD_ALLOC && req.request_size == '0) begin
            st_next = ST_INVALID; gr_next = '0; state_next = S_DONE;
          end else state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = IW'(j + CW'(1));
        if (j == '0) begin
          p_start_next = cur_start; p_used_next = cur_used; pp_used_next = 1'b1;
          j_next = j + CW'(1);
        end else if (cmd == CMD_ALLOC) begin
          if (!p_used && len == LW'(size)) begin
            we = 1'b1; wr_addr = IW'(j - CW'(1)); wr_data = {p_start, 1'b1};
            st_next = ST_OK; gr_next = OffsetW'(p_start); state_next = S_DONE;
          end else if (!p_used && len > LW'(size) && count < CW'(MAX_SEGMENTS)) begin
            // Split: the free tail goes in at j and the later entries move up.
            we = 1'b1; wr_addr = IW'(j - CW'(1)); wr_data = {p_start, 1'b1};
            hold_next = {PW'(LW'(p_start) + LW'(size)), 1'b0};
            rd_addr = IW'(j);
            k_next = j; lim_next = count; count_next = count + CW'(1);
            st_next = ST_OK; gr_next = OffsetW'(p_start); state_next = S_UP;
          end else if (!have) begin
            st_next = ST_NOSPACE; gr_next = '0; state_next = S_DONE;
          end else begin
            p_start_next = cur_start; p_used_next = cur_used;
            pp_used_next = p_used; j_next = j + CW'(1);
          end
        end else begin
          if (MW'(p_start) == MW'(offs)) begin
            st_next = ST_OK; gr_next = '0;
            priority if (!p_used) begin
              st_next = ST_INVALID; state_next = S_DONE;
            end else if (prev_free) begin
              // The freed entry (and a free successor) fold into its predecessor.
              dst = j - CW'(1);
              new_count = count - (next_free ? CW'(2) : CW'(1));
              gap2_next = next_free;
              count_next = new_count; k_next = dst;
              rd_addr = IW'(dst + (next_free ? CW'(2) : CW'(1)));
              state_next = (dst < new_count) ? S_DN : S_DONE;
            end else begin
              we = 1'b1; wr_addr = IW'(j - CW'(1)); wr_data = {p_start, 1'b0};
              if (next_free) begin
                dst = j; new_count = count - CW'(1);
                gap2_next = 1'b0;
                count_next = new_count; k_next = dst;
                rd_addr = IW'(dst + CW'(1));
                state_next = (dst < new_count) ? S_DN : S_DONE;
              end else state_next = S_DONE;
            end
          end else if (!have) begin
            st_next = ST_INVALID; gr_next = '0; state_next = S_DONE;
          end else begin
            p_start_next = cur_start; p_used_next = cur_used;
            pp_used_next = p_used; j_next = j + CW'(1);
          end
        end
      end
      S_UP: begin
        we = 1'b1; wr_addr = IW'(k); wr_data = hold;
        hold_next = rd_data;
        if (k >= lim) state_next = S_DONE;
        else begin
          k_next = k + CW'(1); rd_addr = IW'(k + CW'(1));
        end
      end
      S_DN: begin
        we = 1'b1; wr_addr = IW'(k); wr_data = rd_data;
        if (k + CW'(1) >= count) state_next = S_DONE;
        else begin
          k_next = k + CW'(1); rd_addr = IW'(k + (gap2 ? CW'(3) : CW'(2)));
        end
      end
      S_DONE: begin
        rsp_v_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: src/ffsa_checker.sv
// Port-level checker for the segment allocator, with its bind.
`include "first_fit_segment_allocator_defines.svh"
module ffsa_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] status,
  input logic [14:0] granted_offset
);
  import ffsa_pkg::*;
  `FFSA_ASSERT_IMPL(a_status_code, clk, rst, rsp_valid,
    status == ST_OK || status == ST_NOSPACE || status == ST_INVALID,
    "status out of range")
  `FFSA_ASSERT_IMPL(a_zero_offset, clk, rst, rsp_valid && status != ST_OK,
    granted_offset == '0, "offset not zero on failure")
  `FFSA_ASSERT_IMPL(a_no_take_while_busy, clk, rst, rsp_valid, !req_ready,
    "request taken while response pending")
  `FFSA_ASSERT_NEXT(a_no_resp_at_once, clk, rst, req_valid && req_ready,
    !rsp_valid, "response without latency")
endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .granted_offset(rsp.granted_offset)
);
